[rtl/core/gpr_pkg.sv]
// Package for the GPIO pin register block: register offsets, function codes
// and the access request type passed between the pipeline stages.
// No dependencies.
`default_nettype none

package gpr_pkg;

    // Geometry of the function-select words.
    localparam int FSEL_WORDS      = 4;
    localparam int FIELDS_PER_WORD = 10;
    localparam int FSEL_BITS       = 30;

    // Field widths fixed by the bus.
    localparam int OFFSET_W = 6;
    localparam int DATA_W   = 32;
    localparam int PULL_W   = 2;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Register word offsets.
    localparam logic [OFFSET_W-1:0] OFF_FSEL0   = 6'd0;
    localparam logic [OFFSET_W-1:0] OFF_FSEL1   = 6'd1;
    localparam logic [OFFSET_W-1:0] OFF_FSEL2   = 6'd2;
    localparam logic [OFFSET_W-1:0] OFF_FSEL3   = 6'd3;
    localparam logic [OFFSET_W-1:0] OFF_SET     = 6'd7;
    localparam logic [OFFSET_W-1:0] OFF_CLR     = 6'd10;
    localparam logic [OFFSET_W-1:0] OFF_LEV     = 6'd13;
    localparam logic [OFFSET_W-1:0] OFF_PULL    = 6'd37;
    localparam logic [OFFSET_W-1:0] OFF_PULLCLK = 6'd38;

    // Function code that makes a pin an output.
    localparam logic [2:0] CODE_OUTPUT = 3'b001;

    // One bus access as it moves from the input stage to the register core.
    typedef struct packed {
        logic                kind;
        logic [OFFSET_W-1:0] word_offset;
        logic [DATA_W-1:0]   write_data;
        logic [DATA_W-1:0]   pin_levels;
    } req_t;

endpackage

`default_nettype wire

[rtl/core/gpr_in_stage.sv]
// Input register stage of the GPIO pin register block.
// Captures one access transfer per cycle unless the core stalls it; depends on gpr_pkg.
`default_nettype none

module gpr_in_stage (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // word_offset[5:0], write_data[37:6],
                                        // pin_levels[69:38], zero fill[71:70]
    input  wire logic [0:0]  s_tuser,   // kind[0]
    output logic             req_valid,
    output gpr_pkg::req_t    req,
    input  wire logic        req_ready
);
    import gpr_pkg::*;

    logic valid_reg;
    req_t req_reg;

    // The stage takes a new transfer when empty or when its item moves on.
    assign s_tready  = !valid_reg || req_ready;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg.kind        <= s_tuser[0];
            req_reg.word_offset <= s_tdata[5:0];
            req_reg.write_data  <= s_tdata[37:6];
            req_reg.pin_levels  <= s_tdata[69:38];
        end
    end

endmodule

`default_nettype wire

[rtl/core/gpr_core.sv]
// Register core of the GPIO pin register block: pin state, access decode
// and the result register.  Depends on gpr_pkg.
`default_nettype none

module gpr_core #(
    parameter int NUM_PINS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire gpr_pkg::req_t  req,
    output logic                req_ready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [159:0]        m_tdata
);
    import gpr_pkg::*;

    localparam logic [DATA_W-1:0] PIN_MASK = DATA_W'((64'd1 << NUM_PINS) - 64'd1);

    logic [FSEL_BITS-1:0] fsel_reg  [FSEL_WORDS];
    logic [FSEL_BITS-1:0] fsel_next [FSEL_WORDS];
    logic [FSEL_BITS-1:0] fsel_mask [FSEL_WORDS];
    logic [DATA_W-1:0]    latch_reg, latch_next;
    logic [PULL_W-1:0]    ctrl_reg, ctrl_next;
    logic [PULL_W-1:0]    pull_reg  [NUM_PINS];
    logic [PULL_W-1:0]    pull_next [NUM_PINS];
    logic [DATA_W-1:0]    oe;
    logic [2*DATA_W-1:0]  pulls;
    logic [DATA_W-1:0]    rd;
    logic                 advance;
    logic                 wr;
    logic                 out_valid_reg;
    logic [159:0]         out_data_reg;

    // An item moves into the result register when that register is free.
    assign req_ready = !out_valid_reg || m_tready;
    assign advance   = req_valid && req_ready;
    assign wr        = (req.kind == KIND_WRITE);

    // Function-select bits that belong to existing pins.
    for (genvar w = 0; w < FSEL_WORDS; w++)
    begin : g_mask_word
        for (genvar f = 0; f < FIELDS_PER_WORD; f++)
        begin : g_mask_field
            assign fsel_mask[w][3*f +: 3] =
                (w * FIELDS_PER_WORD + f < NUM_PINS) ? 3'b111 : 3'b000;
        end
    end

    // Next state for a write access.
    always_comb
    begin
        fsel_next  = fsel_reg;
        latch_next = latch_reg;
        ctrl_next  = ctrl_reg;
        pull_next  = pull_reg;
        if (advance && wr)
        begin
            case (req.word_offset)
                OFF_FSEL0, OFF_FSEL1, OFF_FSEL2, OFF_FSEL3:
                begin
                    fsel_next[req.word_offset[1:0]] =
                        req.write_data[FSEL_BITS-1:0] & fsel_mask[req.word_offset[1:0]];
                end
                OFF_SET:
                begin
                    latch_next = (latch_reg | req.write_data) & PIN_MASK;
                end
                OFF_CLR:
                begin
                    latch_next = latch_reg & ~req.write_data & PIN_MASK;
                end
                OFF_PULL:
                begin
                    ctrl_next = req.write_data[PULL_W-1:0];
                end
                OFF_PULLCLK:
                begin
                    for (int n = 0; n < NUM_PINS; n++)
                    begin
                        if (req.write_data[n])
                        begin
                            pull_next[n] = ctrl_reg;
                        end
                    end
                end
                default:
                begin
                    fsel_next = fsel_reg;
                end
            endcase
        end
    end

    // Output enables and packed pull bits as they stand after the access.
    for (genvar n = 0; n < DATA_W; n++)
    begin : g_pin
        if (n < NUM_PINS)
        begin : g_live
            assign oe[n] = (fsel_next[n / FIELDS_PER_WORD][3*(n % FIELDS_PER_WORD) +: 3]
                            == CODE_OUTPUT);
            assign pulls[2*n +: 2] = pull_next[n];
        end
        else
        begin : g_absent
            assign oe[n]           = 1'b0;
            assign pulls[2*n +: 2] = 2'b00;
        end
    end

    // Read data for a read access.
    always_comb
    begin
        rd = '0;
        if (!wr)
        begin
            case (req.word_offset)
                OFF_FSEL0, OFF_FSEL1, OFF_FSEL2, OFF_FSEL3:
                begin
                    rd = DATA_W'(fsel_next[req.word_offset[1:0]]);
                end
                OFF_LEV:
                begin
                    rd = ((latch_next & oe) | (req.pin_levels & ~oe)) & PIN_MASK;
                end
                OFF_PULL:
                begin
                    rd = DATA_W'(ctrl_next);
                end
                default:
                begin
                    rd = '0;
                end
            endcase
        end
    end

    // Pin state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            latch_reg <= '0;
            ctrl_reg  <= '0;
            for (int n = 0; n < NUM_PINS; n++)
            begin
                pull_reg[n] <= '0;
            end
        end
        else
        begin
            fsel_reg  <= fsel_next;
            latch_reg <= latch_next;
            ctrl_reg  <= ctrl_next;
            pull_reg  <= pull_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            out_valid_reg <= req_valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {pulls, oe, latch_next, rd};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/core/gpio_pin_register_block.sv]
// Top level of the GPIO pin register block.
// Instantiates gpr_in_stage and gpr_core; depends on gpr_pkg.
//
// A bank of NUM_PINS general purpose pins behind word-addressed registers.
// Each access transfer on the slave side gives exactly one result transfer
// on the master side, and a new access can be accepted in every cycle while
// the master side is not stalled. An access passes through two register
// stages: the input register, and the result register, which is loaded in
// the same cycle the access updates the pin state. Results report the
// pin-side signals as they stand after the access, and reads at offset 13
// use the pin levels carried with the access.
`default_nettype none

module gpio_pin_register_block #(
    parameter int NUM_PINS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // word_offset[5:0], write_data[37:6],
                                         // pin_levels[69:38], zero fill[71:70]
    input  wire logic [0:0]   s_tuser,   // kind[0]: 0 read, 1 write
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata    // read_data[31:0], pin_drive[63:32],
                                         // pin_output_enable[95:64],
                                         // pull_state[159:96]
);
    import gpr_pkg::*;

    logic req_valid;
    logic req_ready;
    req_t req;

    // Input register.
    gpr_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    // Pin state and result register.
    gpr_core #(
        .NUM_PINS (NUM_PINS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[sim/gpr_pin_checker.sv]
// Checker for the GPIO pin register block: watches the access and result channels,
// keeps its own copy of the register state and compares every result transfer.
// Depends on gpr_pkg for the register offsets, access kinds and function codes.
module gpr_pin_checker #(
    parameter int NUM_PINS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [71:0]  s_tdata,   // word_offset[5:0], write_data[37:6],
                                         // pin_levels[69:38], zero fill[71:70]
    input  wire logic [0:0]   s_tuser,   // kind[0]
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [159:0] m_tdata,   // read_data[31:0], pin_drive[63:32],
                                         // pin_output_enable[95:64],
                                         // pull_state[159:96]
    output int                errors,
    output int                outstanding
);
    import gpr_pkg::*;

    // One result transfer, laid out as on m_tdata (read_data in the lowest bits).
    typedef struct packed {
        logic [63:0] pull_state;
        logic [31:0] output_enable;
        logic [31:0] drive;
        logic [31:0] read_data;
    } pin_result_t;

    localparam logic [31:0] PIN_MASK = (NUM_PINS >= 32) ? 32'hFFFF_FFFF
                                                        : ((32'd1 << NUM_PINS) - 32'd1);

    // Shadow copy of the register state.
    logic [FSEL_BITS-1:0] fsel_words [FSEL_WORDS];
    logic [DATA_W-1:0]    out_latch;
    logic [PULL_W-1:0]    pull_ctl;
    logic [PULL_W-1:0]    pin_pull [32];

    pin_result_t pin_snapshots [$];
    pin_result_t due_result;
    pin_result_t seen_result;
    int          fail_total;

    // Applies one access to the shadow state and returns the result it causes.
    function automatic pin_result_t run_access(logic kind, logic [OFFSET_W-1:0] off,
                                               logic [DATA_W-1:0] data,
                                               logic [DATA_W-1:0] levels);
        pin_result_t r;
        logic [31:0] field_mask;
        logic [2:0]  code;
        r = '0;
        if (kind == KIND_WRITE)
        begin
            if (off <= OFF_FSEL3)
            begin
                // Only the fields of pins that exist are stored.
                field_mask = '0;
                for (int f = 0; f < FIELDS_PER_WORD; f++)
                begin
                    if (int'(off) * FIELDS_PER_WORD + f < NUM_PINS)
                        field_mask |= 32'd7 << (3 * f);
                end
                fsel_words[off[1:0]] = data[FSEL_BITS-1:0] & field_mask[FSEL_BITS-1:0];
            end
            else if (off == OFF_SET)
                out_latch = (out_latch | data) & PIN_MASK;
            else if (off == OFF_CLR)
                out_latch = out_latch & ~data & PIN_MASK;
            else if (off == OFF_PULL)
                pull_ctl = data[PULL_W-1:0];
            else if (off == OFF_PULLCLK)
            begin
                for (int n = 0; n < NUM_PINS; n++)
                begin
                    if (data[n])
                        pin_pull[n] = pull_ctl;
                end
            end
        end

        // Pin-side signals as they stand after the access.
        for (int n = 0; n < NUM_PINS; n++)
        begin
            code = fsel_words[n / FIELDS_PER_WORD][3 * (n % FIELDS_PER_WORD) +: 3];
            r.output_enable[n] = (code == CODE_OUTPUT);
            r.pull_state[2 * n +: 2] = pin_pull[n];
        end
        r.drive = out_latch;

        // Read data; writes and unmapped offsets give zero.
        if (kind == KIND_READ)
        begin
            if (off <= OFF_FSEL3)
                r.read_data = {{(DATA_W - FSEL_BITS){1'b0}}, fsel_words[off[1:0]]};
            else if (off == OFF_LEV)
                r.read_data = ((out_latch & r.output_enable) | (levels & ~r.output_enable))
                              & PIN_MASK;
            else if (off == OFF_PULL)
                r.read_data = {{(DATA_W - PULL_W){1'b0}}, pull_ctl};
        end
        return r;
    endfunction

    task automatic report_failure(string what);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t: %s", $time, what);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            report_failure($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    // Track accepted transfers on both channels.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
                fsel_words[w] = '0;
            for (int n = 0; n < 32; n++)
                pin_pull[n] = '0;
            out_latch = '0;
            pull_ctl = '0;
            pin_snapshots.delete();
            fail_total = 0;
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Results leave only after the input and result registers, so compare before predicting.
            if (m_tvalid && m_tready)
            begin
                seen_result = m_tdata;
                if (pin_snapshots.size() == 0)
                    report_failure($sformatf("result transfer %h with nothing pending",
                                             m_tdata));
                else
                begin
                    due_result = pin_snapshots.pop_front();
                    compare_field("read_data", 64'(due_result.read_data),
                                  64'(seen_result.read_data));
                    compare_field("pin_drive", 64'(due_result.drive),
                                  64'(seen_result.drive));
                    compare_field("pin_output_enable", 64'(due_result.output_enable),
                                  64'(seen_result.output_enable));
                    compare_field("pull_state", due_result.pull_state,
                                  seen_result.pull_state);
                end
            end
            if (s_tvalid && s_tready)
                pin_snapshots.push_back(run_access(s_tuser[0], s_tdata[5:0], s_tdata[37:6],
                                                   s_tdata[69:38]));
            errors <= fail_total;
            outstanding <= pin_snapshots.size();
        end
    end

endmodule

[sim/tb_gpio_pin_register_block.sv]
// Testbench top for the GPIO pin register block: drives register accesses and
// result back-pressure, and gives the verdict from the checker's counts.
// Depends on gpr_pkg, gpio_pin_register_block and gpr_pin_checker.
module tb_gpio_pin_register_block;
    import gpr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 400;
    localparam int SEGMENTS = 8;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;

    int errors;
    int outstanding;
    int quiet_cycles = 0;
    int stall_left = 0;
    int sent = 0;
    logic idle_on = 1'b1;

    gpio_pin_register_block uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gpr_pin_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Result back-pressure: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles in which no transfer happens on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Presents one access and holds it until the transfer completes.
    task automatic send_access(logic kind, logic [OFFSET_W-1:0] off,
                               logic [DATA_W-1:0] data, logic [DATA_W-1:0] levels);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, levels, data, off};
        s_tuser <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Lowers valid and waits until every predicted result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // A function-select word with random codes, output code favored.
    function automatic logic [DATA_W-1:0] random_fsel_word();
        logic [DATA_W-1:0] w;
        w = $urandom;
        for (int f = 0; f < FIELDS_PER_WORD; f++)
        begin
            if ($urandom_range(0, 1) == 0)
                w[3 * f +: 3] = CODE_OUTPUT;
        end
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] random_data();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] random_offset();
        case ($urandom_range(0, 11))
            0, 1: return OFFSET_W'($urandom_range(0, 63));
            2: return OFF_SET;
            3: return OFF_CLR;
            4, 5: return OFF_LEV;
            6: return OFF_PULL;
            7: return OFF_PULLCLK;
            default: return OFFSET_W'($urandom_range(OFF_FSEL0, OFF_FSEL3));
        endcase
    endfunction

    // One random scenario: a pull programming sequence, a pin setup
    // sequence, or a single access.
    task automatic random_scenario();
        logic [OFFSET_W-1:0] off;
        case ($urandom_range(0, 7))
            0:
            begin
                send_access(KIND_WRITE, OFF_PULL, $urandom, $urandom);
                send_access(KIND_WRITE, OFF_PULLCLK, random_data(), $urandom);
                send_access(KIND_READ, OFF_PULL, $urandom, $urandom);
            end
            1:
            begin
                send_access(KIND_WRITE, OFFSET_W'($urandom_range(OFF_FSEL0, OFF_FSEL3)),
                            random_fsel_word(), $urandom);
                send_access(KIND_WRITE, ($urandom_range(0, 1) != 0) ? OFF_SET : OFF_CLR,
                            random_data(), $urandom);
                send_access(KIND_READ, OFF_LEV, $urandom, $urandom);
            end
            default:
            begin
                off = random_offset();
                send_access($urandom_range(0, 1) != 0 ? KIND_WRITE : KIND_READ, off,
                            (off <= OFF_FSEL3 && $urandom_range(0, 1) != 0)
                                ? random_fsel_word() : random_data(),
                            random_data());
            end
        endcase
    endtask

    initial
    begin
        int goal;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed accesses: reset values, field extremes, every register.
        send_access(KIND_READ, OFF_FSEL3, '1, '1);
        send_access(KIND_WRITE, OFF_FSEL0, '1, '0);
        send_access(KIND_READ, OFF_FSEL0, '0, '0);
        send_access(KIND_WRITE, OFF_FSEL3, 32'hFFFF_FF89, '0);
        send_access(KIND_READ, OFF_FSEL3, '0, '1);
        send_access(KIND_WRITE, OFF_FSEL1, 32'h0924_9249, '0);
        send_access(KIND_WRITE, OFF_FSEL2, 32'h1249_2492, '1);
        send_access(KIND_WRITE, OFF_SET, '1, '0);
        send_access(KIND_READ, OFF_SET, '1, '1);
        send_access(KIND_READ, OFF_LEV, '1, '0);
        send_access(KIND_WRITE, OFF_CLR, 32'hAAAA_AAAA, '1);
        send_access(KIND_READ, OFF_LEV, '0, '1);
        send_access(KIND_READ, OFF_CLR, '1, '1);
        send_access(KIND_WRITE, OFF_FSEL0, 32'h1B6D_B6DB, '0);
        send_access(KIND_READ, OFF_LEV, '0, 32'h5555_5555);
        send_access(KIND_WRITE, OFF_PULL, 32'd3, '0);
        send_access(KIND_READ, OFF_PULL, '0, '0);
        send_access(KIND_WRITE, OFF_PULLCLK, '1, '0);
        send_access(KIND_WRITE, OFF_PULL, 32'hFFFF_FFFE, '0);
        send_access(KIND_WRITE, OFF_PULLCLK, 32'h5555_5555, '0);
        send_access(KIND_WRITE, OFF_PULL, 32'd1, '0);
        send_access(KIND_WRITE, OFF_PULLCLK, 32'h8000_0001, '0);
        send_access(KIND_READ, OFF_PULLCLK, '1, '1);
        send_access(KIND_WRITE, 6'd63, '1, '1);
        send_access(KIND_WRITE, OFF_LEV, '1, '1);
        send_access(KIND_READ, 6'd63, '1, '1);

        // Random part in segments; one segment without idling, and the
        // last two without idling as well.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            idle_on = (seg != 2) && (seg < SEGMENTS - 2);
            if (seg == 4)
                drain_results();
            goal = sent + RANDOM_ITEMS / SEGMENTS;
            while (sent < goal)
                random_scenario();
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
